@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ffha_pkg.sv @@
// Types, constants and command codes of the first-fit heap allocator.
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 16;
    localparam int LIMIT_W = 17;
    localparam int REQ_W   = 16;

    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = LIMIT_W'(65536);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_WALK   = 4'd2;
    localparam logic [3:0] OP_HIT    = 4'd3;
    localparam logic [3:0] OP_FOUND  = 4'd4;
    localparam logic [3:0] OP_APPEND = 4'd5;
    localparam logic [3:0] OP_MERGE  = 4'd6;
    localparam logic [3:0] OP_SHIFT  = 4'd7;
    localparam logic [3:0] OP_EMIT   = 4'd8;

    typedef struct packed {
        logic              kind;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] payload_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic              reused;
    } t_out_item;

    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_kind;
        logic in_null;
        logic kind;
        logic cnt_zero;
        logic last;
        logic fit;
        logic match;
        logic all_free;
        logic no_shift;
        logic shift_last;
    } t_dp_status;

endpackage

@@ hw/rtl/ffha_dp.sv @@
// Datapath of the allocator: block table memory, walk registers and result.
`include "assert_macros.svh"
module ffha_dp #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffha_pkg::t_dp_cmd            i_cmd,
    input  ffha_pkg::t_in_item           i_in_data,
    input  logic [ffha_pkg::LIMIT_W-1:0] i_heap_limit,
    output ffha_pkg::t_dp_status         o_status,
    output ffha_pkg::t_out_item          o_result
);
    import ffha_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SIZE_W:0] HDR      = (SIZE_W+1)'(HEADER_BYTES);
    localparam logic [SIZE_W:0] ADDR_MAX = (SIZE_W+1)'((1 << ADDR_W) - 1);
    localparam logic [CW-1:0]   MAXC     = CW'(MAX_BLOCKS);

    t_entry mem [MAX_BLOCKS];
    t_entry r_rdata;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    t_entry        wr_data;

    logic [CW-1:0]     r_count, n_count;
    logic [SIZE_W-1:0] r_top, n_top;
    logic [CW-1:0]     r_idx, n_idx;
    logic [1:0]        r_d, n_d;
    logic [SIZE_W-1:0] r_hdr, n_hdr;
    logic [SIZE_W-1:0] r_prev_size, n_prev_size;
    logic              r_prev_busy, n_prev_busy;
    logic [SIZE_W-1:0] r_cur_size, n_cur_size;
    logic              r_kind;
    logic [REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_paddr;
    t_out_item         r_result, n_result;

    logic              fit, match, has_next, nm, pm;
    logic [SIZE_W:0]   merged, need, top_hdr, walk_sum;
    logic [CW-1:0]     j, new_count, rd_full;
    logic [1:0]        d_new;
    logic [SIZE_W-1:0] lim;
    logic              oom;
    logic              merge_kept;

    always_comb begin
        fit      = !r_rdata.busy && (r_rdata.size >= SIZE_W'(r_req));
        match    = ({1'b0, r_hdr} + HDR) == (SIZE_W+1)'(r_paddr);
        has_next = (r_idx + CW'(1)) < r_count;
        nm       = has_next && !r_rdata.busy;
        pm       = (r_idx != '0) && !r_prev_busy;
        merged   = {1'b0, r_cur_size}
                 + (pm ? ({1'b0, r_prev_size} + HDR) : '0)
                 + (nm ? ({1'b0, r_rdata.size} + HDR) : '0);
        j         = pm ? (r_idx - CW'(1)) : r_idx;
        d_new     = {1'b0, pm} + {1'b0, nm};
        new_count = r_count - CW'(d_new);
        walk_sum  = {1'b0, r_hdr} + HDR + {1'b0, r_rdata.size};
        if (32'(i_heap_limit) > 32'(HEAP_BYTES)) begin
            lim = SIZE_W'(HEAP_BYTES);
        end else begin
            lim = i_heap_limit;
        end
        top_hdr = {1'b0, r_top} + HDR;
        need    = top_hdr + (SIZE_W+1)'(r_req);
        oom     = (need > {1'b0, lim}) || (top_hdr > ADDR_MAX);
    end

    always_comb begin
        case (i_cmd.op)
            OP_WALK, OP_FOUND: rd_full = r_idx + CW'(1);
            OP_MERGE:          rd_full = r_idx + CW'(1) + CW'(nm);
            OP_SHIFT:          rd_full = r_idx + CW'(1) + CW'(r_d);
            default:           rd_full = '0;
        endcase
        rd_addr = rd_full[IW-1:0];
    end

    always_comb begin
        n_count     = r_count;
        n_top       = r_top;
        n_idx       = r_idx;
        n_d         = r_d;
        n_hdr       = r_hdr;
        n_prev_size = r_prev_size;
        n_prev_busy = r_prev_busy;
        n_cur_size  = r_cur_size;
        n_result    = r_result;
        wr_en       = 1'b0;
        wr_addr     = r_idx[IW-1:0];
        wr_data     = r_rdata;
        case (i_cmd.op)
            OP_LOAD: begin
                n_idx       = '0;
                n_hdr       = '0;
                n_prev_busy = 1'b1;
                n_result.result_address = '0;
                n_result.reused         = 1'b0;
                n_result.status = (i_in_data.kind && (i_in_data.payload_address == '0))
                                ? ST_NULL : ST_OK;
            end
            OP_WALK: begin
                n_hdr       = walk_sum[SIZE_W-1:0];
                n_prev_size = r_rdata.size;
                n_prev_busy = r_rdata.busy;
                n_idx       = r_idx + CW'(1);
            end
            OP_HIT: begin
                wr_en        = 1'b1;
                wr_data.busy = 1'b1;
                wr_data.size = r_rdata.size;
                n_result.result_address = ADDR_W'({1'b0, r_hdr} + HDR);
                n_result.status = ST_OK;
                n_result.reused = 1'b1;
            end
            OP_FOUND: begin
                n_cur_size = r_rdata.size;
            end
            OP_APPEND: begin
                if (r_count == MAXC) begin
                    n_result.status = ST_FULL;
                end else if (oom) begin
                    n_result.status = ST_OOM;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = r_count[IW-1:0];
                    wr_data.busy = 1'b1;
                    wr_data.size = SIZE_W'(r_req);
                    n_count      = r_count + CW'(1);
                    n_top        = need[SIZE_W-1:0];
                    n_result.result_address = top_hdr[ADDR_W-1:0];
                    n_result.status = ST_OK;
                end
            end
            OP_MERGE: begin
                if (new_count == CW'(1)) begin
                    n_count = '0;
                    n_top   = '0;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = j[IW-1:0];
                    wr_data.busy = 1'b0;
                    wr_data.size = merged[SIZE_W-1:0];
                    n_count      = new_count;
                    n_idx        = j + CW'(1);
                    n_d          = d_new;
                end
            end
            OP_SHIFT: begin
                wr_en = 1'b1;
                n_idx = r_idx + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_d         <= n_d;
        r_hdr       <= n_hdr;
        r_prev_size <= n_prev_size;
        r_prev_busy <= n_prev_busy;
        r_cur_size  <= n_cur_size;
        r_result    <= n_result;
        if (i_cmd.op == OP_LOAD) begin
            r_kind  <= i_in_data.kind;
            r_req   <= i_in_data.request_size;
            r_paddr <= i_in_data.payload_address;
        end
    end

    always_comb begin
        o_status.in_kind    = i_in_data.kind;
        o_status.in_null    = i_in_data.payload_address == '0;
        o_status.kind       = r_kind;
        o_status.cnt_zero   = r_count == '0;
        o_status.last       = (r_idx + CW'(1)) == r_count;
        o_status.fit        = fit;
        o_status.match      = match;
        o_status.all_free   = new_count == CW'(1);
        o_status.no_shift   = (j + CW'(1)) >= new_count;
        o_status.shift_last = (r_idx + CW'(1)) >= r_count;
    end

    assign o_result   = r_result;
    assign merge_kept = (i_cmd.op == OP_MERGE) && (new_count != CW'(1));

    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= MAXC)
    `ASSERT_IMPLY(a_hit_fits, i_clk, i_rst_n, i_cmd.op == OP_HIT, fit)
    `ASSERT_NEXT(a_merge_keeps, i_clk, i_rst_n, merge_kept, r_count >= CW'(2))

endmodule

@@ hw/rtl/ffha_ctrl.sv @@
// Controller state machine of the allocator.
module ffha_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_free,
    input  ffha_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output ffha_pkg::t_dp_cmd    o_cmd
);
    import ffha_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_FNEXT  = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (!i_status.in_kind) begin
                        n_state = i_status.cnt_zero ? S_APPEND : S_WALK;
                    end else begin
                        n_state = (i_status.in_null || i_status.cnt_zero) ? S_DONE : S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!i_status.kind) begin
                    if (i_status.fit) begin
                        o_cmd.op = OP_HIT;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.op = OP_WALK;
                        if (i_status.last) begin
                            n_state = S_APPEND;
                        end
                    end
                end else begin
                    if (i_status.match) begin
                        o_cmd.op = OP_FOUND;
                        n_state  = S_FNEXT;
                    end else begin
                        o_cmd.op = OP_WALK;
                        if (i_status.last) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_APPEND: begin
                o_cmd.op = OP_APPEND;
                n_state  = S_DONE;
            end
            S_FNEXT: begin
                o_cmd.op = OP_MERGE;
                n_state  = (i_status.all_free || i_status.no_shift) ? S_DONE : S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.op = OP_SHIFT;
                if (i_status.shift_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

endmodule

@@ hw/rtl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with coalescing on free.
//
//  channel   direction  handshake                        payload
//  in        input      i_in_valid / o_in_ready          i_in_data (t_in_item)
//  out       output     o_out_valid / i_out_ready        o_out_data (t_out_item)
//  cfg       input      i_cfg_wr_en                      i_cfg_wr_data (heap limit)
//
// An allocate is accepted, walks the listed blocks until one fits and, if none fits, makes the
// append decision; the result then goes into the output register once that register is free.
// A free is accepted; if it finds its block, it walks up to and including it, merges, moves
// the following entries one at a time and loads the output register once that is free.
// The walk and the entry moves are bound by the single read port of the block table.
// Reset is synchronous and empties the list; the table needs no clearing pass.
// A transaction is held in the output register while the consumer stalls.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ffha_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ffha_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_wr_en,
    input  logic [ffha_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import ffha_pkg::*;

    t_dp_cmd          cmd;
    t_dp_status       status;
    t_out_item        result;
    logic             out_free;
    logic [LIMIT_W-1:0] r_heap_limit;
    logic             r_out_valid;
    t_out_item        r_out_data;

    assign out_free = !r_out_valid || i_out_ready;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_data    (i_in_data),
        .i_heap_limit (r_heap_limit),
        .o_status     (status),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= HEAP_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_heap_limit <= i_cfg_wr_data;
            end
            if (cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.op == OP_EMIT) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
